// File: src/lfuto_pkg.sv
// Shared definitions for the LFU table with oldest-first tie-break.
// Parameter defaults, register map, controller states and command/status structs.
// No dependencies.
package lfuto_pkg;

   localparam int FRAMES_DEF     = 16;
   localparam int ID_BITS_DEF    = 8;
   localparam int COUNT_BITS_DEF = 16;

   // word field widths on the ports
   localparam int REQ_ID_W   = 8;
   localparam int RSP_SLOT_W = 4;
   localparam int RSP_ID_W   = 8;
   localparam int RSP_CNT_W  = 16;

   // register map: index is paddr[2]
   localparam logic       REG_FRAMES_IN_USE = 1'b0;
   localparam logic [4:0] FRAMES_IN_USE_RST = 5'd16;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic start;
      logic scan;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic out_free;
   } status_type;

endpackage

// File: src/lfu_table_oldest_tiebreak.sv
// Top level of the LFU table with oldest-first tie-break: register port and wiring.
// Depends on lfuto_pkg, lfuto_ctrl, lfuto_dpath.
//
//   port group   dir   kind        contents
//   req_*        in    stream      student_id
//   rsp_*        out   stream      hit, evicted / slot, evicted_id, use_count
//   csr_*        in    APB         frames_in_use at 0x0
//
// With N entries occupied (1 to FRAMES) the result word follows the accepted input
// word after N reads through a single read port, one registered compare, closing
// the scan, then the commit. An empty table skips the reads and the compare.
// The next word is accepted the cycle after the commit; one item in flight at a time.
// A stalled result holds the commit until the output register frees.
// Reset is synchronous; it clears occupancy and the request counter and sets the
// register to 16.
module lfu_table_oldest_tiebreak #(
   parameter int FRAMES     = lfuto_pkg::FRAMES_DEF,
   parameter int ID_BITS    = lfuto_pkg::ID_BITS_DEF,
   parameter int COUNT_BITS = lfuto_pkg::COUNT_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] student_id
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,    // [3:0] slot, [11:4] evicted_id, [27:12] use_count
   output logic [1:0]  rsp_tuser,    // [0] hit, [1] evicted
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import lfuto_pkg::*;

   logic [4:0] frames_ff;
   logic       csr_wr;
   cmd_type    cmd;
   status_type status;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_ff <= FRAMES_IN_USE_RST;
      end else if (csr_wr && (csr_paddr[2] == REG_FRAMES_IN_USE)) begin
         frames_ff <= csr_pwdata[4:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_FRAMES_IN_USE) ? {27'd0, frames_ff} : 32'd0;

   lfuto_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   lfuto_dpath #(
      .FRAMES     (FRAMES),
      .ID_BITS    (ID_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .frames_in_use (frames_ff),
      .req_id        (req_tdata),
      .rsp_tready    (rsp_tready),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser)
   );

endmodule

// File: src/lfuto_ctrl.sv
// Controller for the LFU table: accept, scan, commit sequencing.
// Depends on lfuto_pkg; drives lfuto_dpath through cmd_type / status_type.
module lfuto_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  lfuto_pkg::status_type  status,
   output lfuto_pkg::cmd_type     cmd
);
   import lfuto_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (status.scan_done) state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.start  = req_tvalid;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
         end
         ST_COMMIT: begin
            cmd.commit = status.out_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

endmodule

// File: src/lfuto_dpath.sv
// Datapath for the LFU table: entry memories, match/victim scan, update, result register.
// Depends on lfuto_pkg; commanded by lfuto_ctrl.
module lfuto_dpath #(
   parameter int FRAMES     = lfuto_pkg::FRAMES_DEF,
   parameter int ID_BITS    = lfuto_pkg::ID_BITS_DEF,
   parameter int COUNT_BITS = lfuto_pkg::COUNT_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  lfuto_pkg::cmd_type     cmd,
   output lfuto_pkg::status_type  status,
   input  logic [4:0]             frames_in_use,
   input  logic [7:0]             req_id,
   input  logic                   rsp_tready,
   output logic                   rsp_tvalid,
   output logic [31:0]            rsp_tdata,
   output logic [1:0]             rsp_tuser
);
   import lfuto_pkg::*;

   localparam int IDX_BITS = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int CNT_W    = $clog2(FRAMES + 1);
   localparam int LW       = ((CNT_W > 5) ? CNT_W : 5) + 1;

   logic [ID_BITS-1:0]    ident_mem [FRAMES];
   logic [COUNT_BITS-1:0] uses_mem  [FRAMES];
   logic [31:0]           stamp_mem [FRAMES];

   logic [ID_BITS-1:0]    id_ff;
   logic [CNT_W-1:0]      ptr_ff;
   logic [CNT_W-1:0]      used_ff;
   logic [31:0]           reqnum_ff;
   logic                  rd_pend_ff;
   logic [IDX_BITS-1:0]   rd_idx_ff;
   logic [ID_BITS-1:0]    rd_ident_ff;
   logic [COUNT_BITS-1:0] rd_uses_ff;
   logic [31:0]           rd_stamp_ff;
   logic                  found_ff;
   logic [IDX_BITS-1:0]   match_idx_ff;
   logic [COUNT_BITS-1:0] match_uses_ff;
   logic                  have_ff;
   logic [IDX_BITS-1:0]   best_idx_ff;
   logic [COUNT_BITS-1:0] best_uses_ff;
   logic [31:0]           best_stamp_ff;
   logic [ID_BITS-1:0]    best_ident_ff;
   logic                  rsp_valid_ff;
   logic [31:0]           rsp_data_ff;
   logic [1:0]            rsp_user_ff;

   logic [ID_BITS+REQ_ID_W-1:0]     id_wide;
   logic                            issue;
   logic                            match;
   logic                            better;
   logic [LW-1:0]                   fiu_eff;
   logic                            free;
   logic [COUNT_BITS-1:0]           hit_uses;
   logic [IDX_BITS-1:0]             slot_idx;
   logic                            evict;
   logic [COUNT_BITS-1:0]           cnt_out;
   logic [IDX_BITS+RSP_SLOT_W-1:0]  slot_wide;
   logic [ID_BITS+RSP_ID_W-1:0]     evid_wide;
   logic [COUNT_BITS+RSP_CNT_W-1:0] cnt_wide;

   assign id_wide = {{ID_BITS{1'b0}}, req_id};
   assign issue   = (ptr_ff < used_ff);
   assign match   = (rd_ident_ff == id_ff);
   assign better  = !have_ff || (rd_uses_ff < best_uses_ff) ||
                    ((rd_uses_ff == best_uses_ff) &&
                     ((rd_stamp_ff < best_stamp_ff) ||
                      ((rd_stamp_ff == best_stamp_ff) && (rd_ident_ff < best_ident_ff))));

   // register value 0 behaves as 1
   assign fiu_eff  = (frames_in_use == 5'd0) ? LW'(1) : LW'(frames_in_use);
   assign free     = (LW'(used_ff) < LW'(FRAMES)) && (LW'(used_ff) < fiu_eff);
   assign hit_uses = (match_uses_ff == {COUNT_BITS{1'b1}}) ? match_uses_ff
                                                            : match_uses_ff + COUNT_BITS'(1);
   assign evict    = !found_ff && !free;
   assign slot_idx = found_ff ? match_idx_ff : (free ? used_ff[IDX_BITS-1:0] : best_idx_ff);
   assign cnt_out  = found_ff ? hit_uses : COUNT_BITS'(1);

   assign slot_wide = {{RSP_SLOT_W{1'b0}}, slot_idx};
   assign evid_wide = {{RSP_ID_W{1'b0}}, (evict ? best_ident_ff : {ID_BITS{1'b0}})};
   assign cnt_wide  = {{RSP_CNT_W{1'b0}}, cnt_out};

   assign status.scan_done = !issue && !rd_pend_ff;
   assign status.out_free  = !rsp_valid_ff || rsp_tready;

   // entry memories
   always_ff @(posedge clock) begin
      if (cmd.scan && issue) begin
         rd_ident_ff <= ident_mem[ptr_ff[IDX_BITS-1:0]];
         rd_uses_ff  <= uses_mem[ptr_ff[IDX_BITS-1:0]];
         rd_stamp_ff <= stamp_mem[ptr_ff[IDX_BITS-1:0]];
         rd_idx_ff   <= ptr_ff[IDX_BITS-1:0];
      end
      if (cmd.commit) begin
         if (found_ff) begin
            uses_mem[slot_idx] <= hit_uses;
         end else begin
            ident_mem[slot_idx] <= id_ff;
            uses_mem[slot_idx]  <= COUNT_BITS'(1);
            stamp_mem[slot_idx] <= reqnum_ff;
         end
      end
   end

   // scan control and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff       <= '0;
         rd_pend_ff   <= 1'b0;
         found_ff     <= 1'b0;
         have_ff      <= 1'b0;
         used_ff      <= '0;
         reqnum_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.start) begin
            ptr_ff     <= '0;
            rd_pend_ff <= 1'b0;
            found_ff   <= 1'b0;
            have_ff    <= 1'b0;
         end
         if (cmd.scan) begin
            rd_pend_ff <= issue;
            if (issue) ptr_ff <= ptr_ff + CNT_W'(1);
            if (rd_pend_ff) begin
               if (match) found_ff <= 1'b1;
               have_ff <= 1'b1;
            end
         end
         if (cmd.commit) begin
            if (!found_ff && free) used_ff <= used_ff + CNT_W'(1);
            if (reqnum_ff != 32'hFFFF_FFFF) reqnum_ff <= reqnum_ff + 32'd1;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // scan payload and result word
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         id_ff <= id_wide[ID_BITS-1:0];
      end
      if (cmd.scan && rd_pend_ff) begin
         if (match && !found_ff) begin
            match_idx_ff  <= rd_idx_ff;
            match_uses_ff <= rd_uses_ff;
         end
         if (better) begin
            best_idx_ff   <= rd_idx_ff;
            best_uses_ff  <= rd_uses_ff;
            best_stamp_ff <= rd_stamp_ff;
            best_ident_ff <= rd_ident_ff;
         end
      end
      if (cmd.commit) begin
         rsp_data_ff <= {4'b0000, cnt_wide[RSP_CNT_W-1:0], evid_wide[RSP_ID_W-1:0],
                         slot_wide[RSP_SLOT_W-1:0]};
         rsp_user_ff <= {evict, found_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// File: src/lfuto_check.sv
// Port-level checks for the LFU table, bound to lfu_table_oldest_tiebreak.
// Depends only on the top-level ports.
module lfuto_check (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result word changed while stalled");

   // one word in flight: accept closes the input
   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input accepted twice in a row");

   // a hit never evicts, and a word without eviction carries a zero id
   a_evict_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]) &&
                     (rsp_tuser[1] || (rsp_tdata[11:4] == 8'd0)))
      else $error("inconsistent eviction fields");

   // a miss installs with count one
   a_miss_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> (rsp_tdata[27:12] == 16'd1) && (rsp_tdata[31:28] == 4'd0))
      else $error("miss result with count other than one");

endmodule

bind lfu_table_oldest_tiebreak lfuto_check u_lfuto_check (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
